/* hw/rtl/zrad_pkg.sv */
// ----------------------------------------------------------------------------
// zrad_pkg
// Shared types and constants of the per-channel rate z-score detector.
// ----------------------------------------------------------------------------
`default_nettype none

package zrad_pkg;

  localparam int ChannelW    = 4;
  localparam int SampleW     = 32;
  localparam int SumOutW     = 36;
  localparam int CfgW        = 8;
  localparam int NumChanMaxC = 2 ** ChannelW;

  localparam int HistoryDefC  = 10;
  localparam int ChannelsDefC = 16;

  localparam logic [CfgW-1:0] SigmaResetC = 8'd48;

  // threshold is in 1/16 sigma, so its square carries a 2^8 scale
  localparam int FracShiftC = 8;

  // operand slice width of the shared multiplier
  localparam int MulPieceC = 18;

  typedef enum logic [1:0] {
    STAT_COLLECT = 2'd0,
    STAT_FLAT    = 2'd1,
    STAT_NORMAL  = 2'd2,
    STAT_ANOMALY = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_META,
    ST_WALK,
    ST_DRAIN,
    ST_SQ,
    ST_SQ_WAIT,
    ST_QCALC,
    ST_FLAT,
    ST_DSQ,
    ST_DSQ_WAIT,
    ST_RHS,
    ST_RHS_WAIT,
    ST_CMP,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [ChannelW-1:0] channel;
    logic [SampleW-1:0]  rate_sample;
  } in_word_t;

  typedef struct packed {
    logic [ChannelW-1:0] out_channel;
    logic [SampleW-1:0]  out_sample;
    status_e             status;
    logic [SumOutW-1:0]  window_sum;
  } out_word_t;

endpackage

`default_nettype wire

/* hw/rtl/zscore_rate_anomaly_detector.sv */
// ----------------------------------------------------------------------------
// zscore_rate_anomaly_detector
// Per-channel sliding-window z-score check of byte-rate samples.
// ----------------------------------------------------------------------------
// One word is processed at a time. A judged sample walks its whole window
// through the single read port of the window memory, one entry per cycle,
// and then uses the one shared 36x18 multiplier, which forms S^2, the squared
// deviation and the threshold product in slices. A sample that meets a flat
// window skips the squared deviation and the threshold product, a sample still
// filling the baseline stops after the metadata read, and a channel number at
// or above CHANNELS skips all of them. A new word is taken while the previous
// result still waits in the output register.
`default_nettype none

module zscore_rate_anomaly_detector #(
  parameter int HISTORY  = zrad_pkg::HistoryDefC,
  parameter int CHANNELS = zrad_pkg::ChannelsDefC
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        cfg_we_i,
  input  wire [zrad_pkg::CfgW-1:0]   cfg_wdata_i,
  input  wire                        in_valid_i,
  output logic                       in_ready_o,
  input  zrad_pkg::in_word_t         in_data_i,
  output logic                       out_valid_o,
  input  wire                        out_ready_i,
  output zrad_pkg::out_word_t        out_data_o
);

  import zrad_pkg::*;

  localparam int NumCh  = (CHANNELS < NumChanMaxC) ? CHANNELS : NumChanMaxC;
  localparam int CW     = (NumCh > 1) ? $clog2(NumCh) : 1;
  localparam int Depth  = NumCh * HISTORY;
  localparam int AW     = $clog2(Depth);
  localparam int PW     = $clog2(HISTORY);
  localparam int FW     = $clog2(HISTORY + 1);
  localparam int MW     = FW + PW;
  localparam int LogH   = $clog2(HISTORY);
  localparam int SumW   = SampleW + LogH;
  localparam int SqSumW = 2 * SampleW + LogH;
  localparam int QW     = 2 * SumW;
  localparam int TsqW   = 2 * CfgW;
  localparam int AccW   = QW + TsqW;
  localparam int LhsW   = QW + FracShiftC;
  localparam int NPs    = (SumW + MulPieceC - 1) / MulPieceC;
  localparam int NPq    = (QW + MulPieceC - 1) / MulPieceC;
  localparam int KW     = $clog2(NPq);
  localparam int MulW   = SumW + MulPieceC;
  localparam int ShW    = $clog2(AccW);

  // storage
  logic [SampleW-1:0] win_mem [Depth];
  logic [MW-1:0]      meta_mem [NumCh];
  logic [NumCh-1:0]   meta_vld_q;

  // control
  state_e             state_q, state_d;
  logic               out_valid_q, out_valid_d;
  logic               v1_q, v1_d, v2_q, v2_d;
  logic               pend_q, pend_d;
  logic [TsqW-1:0]    tsq_q;

  // datapath
  logic [ChannelW-1:0] ch_q, ch_d;
  logic [SampleW-1:0]  x_q, x_d;
  logic [SumW-1:0]     nx_q, nx_d;
  logic [AW-1:0]       base_q, base_d;
  logic [PW-1:0]       i_q, i_d;
  logic [KW-1:0]       k_q, k_d;
  logic [ShW-1:0]      sh_q, sh_d;
  logic [SampleW-1:0]  win_rd_q;
  logic [MW-1:0]       meta_rd_q;
  logic                meta_vrd_q;
  logic [2*SampleW-1:0] sq_q, sq_d;
  logic [SumW-1:0]     s_q, s_d;
  logic [SqSumW-1:0]   sumsq_q, sumsq_d;
  logic [QW-1:0]       nsq_q, nsq_d;
  logic [QW-1:0]       q_q, q_d;
  logic [SumW-1:0]     d_q, d_d;
  logic [LhsW-1:0]     lhs_q, lhs_d;
  logic [AccW-1:0]     acc_q, acc_d;
  logic [MulW-1:0]     mul_p_q, mul_p_d;
  status_e             res_status_q, res_status_d;
  logic [SumW-1:0]     res_sum_q, res_sum_d;
  out_word_t           out_q, out_d;

  // memory strobes
  logic               win_we, win_re, meta_we, meta_re;
  logic [AW-1:0]      win_waddr, win_raddr;
  logic [MW-1:0]      meta_wdata;
  logic [CW-1:0]      meta_ridx;

  // combinational helpers
  logic [FW-1:0]             cur_fill, nxt_fill;
  logic [PW-1:0]             cur_pos, nxt_pos;
  logic [NPs*MulPieceC-1:0]  s_pad, d_pad;
  logic [NPq*MulPieceC-1:0]  q_pad;
  logic [ShW-1:0]            sh_amt;
  logic [SumW-1:0]           mul_a;
  logic [MulPieceC-1:0]      mul_b;
  logic                      acc_clr;
  logic                      in_range;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign in_range  = (32'(in_data_i.channel) < NumCh);
  assign meta_ridx = in_data_i.channel[CW-1:0];

  assign cur_fill = meta_vrd_q ? meta_rd_q[MW-1:PW] : '0;
  assign cur_pos  = meta_vrd_q ? meta_rd_q[PW-1:0] : '0;
  assign nxt_pos  = (cur_pos == PW'(HISTORY - 1)) ? '0 : cur_pos + 1'b1;
  assign nxt_fill = (cur_fill < FW'(HISTORY)) ? cur_fill + 1'b1 : cur_fill;

  assign sh_amt = ShW'(k_q) * ShW'(MulPieceC);

  always_comb begin
    s_pad = '0;
    s_pad[SumW-1:0] = s_q;
    d_pad = '0;
    d_pad[SumW-1:0] = d_q;
    q_pad = '0;
    q_pad[QW-1:0] = q_q;
  end

  always_comb begin
    state_d      = state_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_d        = out_q;
    ch_d         = ch_q;
    x_d          = x_q;
    nx_d         = nx_q;
    base_d       = base_q;
    i_d          = i_q;
    k_d          = k_q;
    sh_d         = sh_q;
    s_d          = s_q;
    sumsq_d      = sumsq_q;
    sq_d         = sq_q;
    nsq_d        = nsq_q;
    q_d          = q_q;
    d_d          = d_q;
    lhs_d        = lhs_q;
    res_status_d = res_status_q;
    res_sum_d    = res_sum_q;
    pend_d       = 1'b0;
    acc_clr      = 1'b0;
    mul_a        = '0;
    mul_b        = '0;
    win_we       = 1'b0;
    win_re       = 1'b0;
    meta_we      = 1'b0;
    meta_re      = 1'b0;
    win_waddr    = base_q + AW'(cur_pos);
    win_raddr    = base_q + AW'(i_q);
    meta_wdata   = {nxt_fill, nxt_pos};
    v1_d         = 1'b0;
    v2_d         = v1_q;

    // window walk pipeline: read data, square, accumulate
    if (v1_q) begin
      sq_d = (2 * SampleW)'(win_rd_q) * (2 * SampleW)'(win_rd_q);
      s_d  = s_q + SumW'(win_rd_q);
    end
    if (v2_q) begin
      sumsq_d = sumsq_q + SqSumW'(sq_q);
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ch_d   = in_data_i.channel;
          x_d    = in_data_i.rate_sample;
          nx_d   = SumW'(in_data_i.rate_sample) * SumW'(HISTORY);
          base_d = AW'(AW'(in_data_i.channel) * AW'(HISTORY));
          if (in_range) begin
            meta_re = 1'b1;
            state_d = ST_META;
          end else begin
            res_status_d = STAT_COLLECT;
            res_sum_d    = '0;
            state_d      = ST_DONE;
          end
        end
      end
      ST_META: begin
        win_we  = 1'b1;
        meta_we = 1'b1;
        if (cur_fill < FW'(HISTORY)) begin
          res_status_d = STAT_COLLECT;
          res_sum_d    = '0;
          state_d      = ST_DONE;
        end else begin
          i_d     = '0;
          s_d     = '0;
          sumsq_d = '0;
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        win_re = 1'b1;
        v1_d   = 1'b1;
        i_d    = i_q + 1'b1;
        if (i_q == PW'(HISTORY - 1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!v1_q && !v2_q) begin
          acc_clr = 1'b1;
          k_d     = '0;
          state_d = ST_SQ;
        end
      end
      ST_SQ: begin
        nsq_d  = QW'(sumsq_q) * QW'(HISTORY);
        mul_a  = s_q;
        mul_b  = MulPieceC'(s_pad >> sh_amt);
        pend_d = 1'b1;
        sh_d   = sh_amt;
        k_d    = k_q + 1'b1;
        if (k_q == KW'(NPs - 1)) begin
          state_d = ST_SQ_WAIT;
        end
      end
      ST_SQ_WAIT: begin
        state_d = ST_QCALC;
      end
      ST_QCALC: begin
        q_d     = nsq_q - acc_q[QW-1:0];
        d_d     = (nx_q >= s_q) ? nx_q - s_q : s_q - nx_q;
        acc_clr = 1'b1;
        state_d = ST_FLAT;
      end
      ST_FLAT: begin
        k_d = '0;
        if (q_q == '0) begin
          res_status_d = STAT_FLAT;
          res_sum_d    = s_q;
          state_d      = ST_DONE;
        end else begin
          state_d = ST_DSQ;
        end
      end
      ST_DSQ: begin
        mul_a  = d_q;
        mul_b  = MulPieceC'(d_pad >> sh_amt);
        pend_d = 1'b1;
        sh_d   = sh_amt;
        k_d    = k_q + 1'b1;
        if (k_q == KW'(NPs - 1)) begin
          k_d     = '0;
          state_d = ST_DSQ_WAIT;
        end
      end
      ST_DSQ_WAIT: begin
        state_d = ST_RHS;
      end
      ST_RHS: begin
        // first slice: the deviation square is complete, move it out
        if (k_q == '0) begin
          lhs_d   = LhsW'(acc_q[QW-1:0]) << FracShiftC;
          acc_clr = 1'b1;
        end
        mul_a  = SumW'(tsq_q);
        mul_b  = MulPieceC'(q_pad >> sh_amt);
        pend_d = 1'b1;
        sh_d   = sh_amt;
        k_d    = k_q + 1'b1;
        if (k_q == KW'(NPq - 1)) begin
          state_d = ST_RHS_WAIT;
        end
      end
      ST_RHS_WAIT: begin
        state_d = ST_CMP;
      end
      ST_CMP: begin
        res_status_d = (AccW'(lhs_q) > acc_q) ? STAT_ANOMALY : STAT_NORMAL;
        res_sum_d    = s_q;
        state_d      = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.out_channel = ch_q;
          out_d.out_sample  = x_q;
          out_d.status      = res_status_q;
          out_d.window_sum  = SumOutW'(res_sum_q);
          out_valid_d       = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    mul_p_d = MulW'(mul_a) * MulW'(mul_b);

    if (acc_clr) begin
      acc_d = '0;
    end else if (pend_q) begin
      acc_d = acc_q + (AccW'(mul_p_q) << sh_q);
    end else begin
      acc_d = acc_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      pend_q      <= 1'b0;
      meta_vld_q  <= '0;
      tsq_q       <= TsqW'(SigmaResetC) * TsqW'(SigmaResetC);
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      v1_q        <= v1_d;
      v2_q        <= v2_d;
      pend_q      <= pend_d;
      if (meta_we) begin
        meta_vld_q[ch_q[CW-1:0]] <= 1'b1;
      end
      if (cfg_we_i) begin
        tsq_q <= TsqW'(cfg_wdata_i) * TsqW'(cfg_wdata_i);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    ch_q         <= ch_d;
    x_q          <= x_d;
    nx_q         <= nx_d;
    base_q       <= base_d;
    i_q          <= i_d;
    k_q          <= k_d;
    sh_q         <= sh_d;
    sq_q         <= sq_d;
    s_q          <= s_d;
    sumsq_q      <= sumsq_d;
    nsq_q        <= nsq_d;
    q_q          <= q_d;
    d_q          <= d_d;
    lhs_q        <= lhs_d;
    acc_q        <= acc_d;
    mul_p_q      <= mul_p_d;
    res_status_q <= res_status_d;
    res_sum_q    <= res_sum_d;
    out_q        <= out_d;
  end

  // sample window memory
  always_ff @(posedge clk_i) begin
    if (win_we) begin
      win_mem[win_waddr] <= x_q;
    end
    if (win_re) begin
      win_rd_q <= win_mem[win_raddr];
    end
  end

  // per-channel fill count and write position
  always_ff @(posedge clk_i) begin
    if (meta_we) begin
      meta_mem[ch_q[CW-1:0]] <= meta_wdata;
    end
    if (meta_re) begin
      meta_rd_q  <= meta_mem[meta_ridx];
      meta_vrd_q <= meta_vld_q[meta_ridx];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/zrad_checker.sv */
// ----------------------------------------------------------------------------
// zrad_checker
// Port-level checks of the rate z-score detector, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module zrad_checker (
  input wire                        clk_i,
  input wire                        rst_ni,
  input wire                        cfg_we_i,
  input wire [zrad_pkg::CfgW-1:0]   cfg_wdata_i,
  input wire                        in_valid_i,
  input wire                        in_ready_o,
  input zrad_pkg::in_word_t         in_data_i,
  input wire                        out_valid_o,
  input wire                        out_ready_i,
  input zrad_pkg::out_word_t        out_data_o
);

  import zrad_pkg::*;

  logic       in_acc, out_acc;
  logic [2:0] pend_q, pend_d;
  logic       cfg_seen;

  assign in_acc   = in_valid_i && in_ready_o;
  assign out_acc  = out_valid_o && out_ready_i;
  assign cfg_seen = cfg_we_i && (cfg_wdata_i == cfg_wdata_i);

  // words accepted and not yet answered
  always_comb begin
    pend_d = pend_q;
    if (in_acc && !out_acc) begin
      pend_d = pend_q + 3'd1;
    end else if (!in_acc && out_acc) begin
      pend_d = pend_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word dropped or changed while stalled");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 3'd0)
    else $error("result word without an accepted input word");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 3'd2)
    else $error("more words in flight than the block can hold");

  a_collect_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == STAT_COLLECT) && !cfg_seen
      |-> out_data_o.window_sum == '0)
    else $error("baseline result carries a nonzero window sum");

endmodule

bind zscore_rate_anomaly_detector zrad_checker u_zrad_checker (.*);

`default_nettype wire

/* test/zscore_rate_anomaly_detector_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zscore_rate_anomaly_detector_tb
// Self-checking bench for the per-channel rate z-score detector. Sample words
// go in through a queue-fed driver with random gaps. A monitor with random
// back-pressure compares every result word against an in-bench scoreboard
// model of the windows, sums and exact integer threshold test. The threshold
// register is swept across several settings, the rails included.
// ----------------------------------------------------------------------------
module zscore_rate_anomaly_detector_tb;
  import zrad_pkg::*;

  localparam int HistC       = HistoryDefC;
  localparam int ChanC       = ChannelsDefC;
  localparam int RandWordsC  = 275;
  localparam int PhasesC     = 5;
  localparam int MaxGapC     = 14;
  localparam int HoldAtC     = 400;
  localparam int HoldCyclesC = 300;
  localparam int ReportMaxC  = 10;
  localparam int TailCyclesC = 4 * HistC + 20;
  localparam int AccW        = SampleW + 8;
  localparam logic [SampleW-1:0] RailC = '1;

  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            cfg_we_i    = 1'b0;
  logic [CfgW-1:0] cfg_wdata_i = '0;
  logic            in_valid_i  = 1'b0;
  logic            in_ready_o;
  in_word_t        in_data_i   = '0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  out_word_t       out_data_o;

  zscore_rate_anomaly_detector #(
    .HISTORY  (HistC),
    .CHANNELS (ChanC)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // scoreboard copy of the detector state
  logic [SampleW-1:0] win_mem  [ChanC][HistC];
  int unsigned        wr_pos   [ChanC];
  int unsigned        fill_cnt [ChanC];
  logic [CfgW-1:0]    sigma_q = SigmaResetC;

  // stimulus shaping per channel
  logic [SampleW-1:0] base_rate [ChanC];
  logic [SampleW-1:0] spread    [ChanC];

  in_word_t    rate_words_q [$];
  out_word_t   verdict_q    [$];
  int unsigned words_queued;
  int unsigned words_taken;
  int unsigned results_seen;
  int unsigned mismatch_cnt;
  int unsigned status_seen [4];
  int          tx_wait;
  int          rx_wait;
  int          tx_max_gap = MaxGapC;
  int          rx_max_stall = MaxGapC;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // exact integer form of |z| > t/16, all terms kept in 128 bits
  function automatic out_word_t judge_rate_sample(in_word_t w);
    out_word_t    r;
    int unsigned  ch, pos;
    logic [127:0] x, s, sq, v, q, nx, d, lhs, rhs, tt, hist;
    r.out_channel = w.channel;
    r.out_sample  = w.rate_sample;
    r.status      = STAT_COLLECT;
    r.window_sum  = '0;
    ch = 32'(w.channel);
    if (ch >= ChanC) return r;
    pos = wr_pos[ch];
    if (pos >= HistC) pos = 0;
    win_mem[ch][pos] = w.rate_sample;
    wr_pos[ch] = (pos + 1 >= HistC) ? 0 : pos + 1;
    if (fill_cnt[ch] < HistC) begin
      fill_cnt[ch]++;
      return r;
    end
    hist = 128'(HistC);
    x    = 128'(w.rate_sample);
    s    = '0;
    sq   = '0;
    for (int i = 0; i < HistC; i++) begin
      v  = 128'(win_mem[ch][i]);
      s  = s + v;
      sq = sq + v * v;
    end
    q = sq * hist - s * s;
    if (q == '0) begin
      r.status = STAT_FLAT;
    end else begin
      nx  = x * hist;
      d   = (nx >= s) ? nx - s : s - nx;
      lhs = (d * d) << FracShiftC;
      tt  = 128'(sigma_q);
      rhs = q * (tt * tt);
      r.status = (lhs > rhs) ? STAT_ANOMALY : STAT_NORMAL;
    end
    r.window_sum = s[SumOutW-1:0];
    return r;
  endfunction

  task automatic push_rate_word(logic [ChannelW-1:0] ch, logic [SampleW-1:0] x);
    in_word_t w;
    w.channel     = ch;
    w.rate_sample = x;
    rate_words_q.push_back(w);
    words_queued++;
  endtask

  // channels get a base rate and a noise spread; spread 0 keeps the ordinary words equal, so flat windows can form
  task automatic push_random_words(int n);
    logic [AccW-1:0]     acc;
    logic [SampleW-1:0]  x;
    logic [ChannelW-1:0] ch;
    int unsigned         sel;
    for (int c = 0; c < ChanC; c++) begin
      case ($urandom_range(0, 3))
        0:       base_rate[c] = $urandom;
        1:       base_rate[c] = $urandom_range(0, 1000);
        2:       base_rate[c] = RailC - $urandom_range(0, 1000);
        default: base_rate[c] = $urandom_range(1000, 100000000);
      endcase
      case ($urandom_range(0, 4))
        0:       spread[c] = '0;
        1:       spread[c] = SampleW'(3);
        2:       spread[c] = SampleW'(255);
        3:       spread[c] = SampleW'(65535);
        default: spread[c] = $urandom;
      endcase
    end
    repeat (n) begin
      ch  = ChannelW'($urandom_range(0, ChanC - 1));
      sel = $urandom_range(0, 19);
      if (sel == 0) begin
        x = $urandom;
      end else if (sel == 1) begin
        x = ($urandom_range(0, 1) != 0) ? RailC : '0;
      end else begin
        acc = AccW'(base_rate[ch]);
        if (sel == 2) acc = acc + (AccW'(spread[ch]) << 3) + AccW'(64);  // spike
        else acc = acc + AccW'($urandom_range(0, spread[ch]));
        x = (acc > AccW'(RailC)) ? RailC : acc[SampleW-1:0];
      end
      push_rate_word(ch, x);
    end
  endtask

  task automatic write_sigma(logic [CfgW-1:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sigma_q = v;
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (words_taken != words_queued || verdict_q.size() != 0);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : word_driver
    out_word_t verdict;
    logic      offering;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else begin
      offering = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        verdict = judge_rate_sample(in_data_i);
        verdict_q.push_back(verdict);
        status_seen[verdict.status]++;
        words_taken++;
        tx_wait  = $urandom_range(0, tx_max_gap);
        offering = 1'b0;
      end
      if (!offering) begin
        if (tx_wait > 0) begin
          tx_wait--;
        end else if (rate_words_q.size() != 0) begin
          in_data_i <= rate_words_q.pop_front();
          offering = 1'b1;
        end
      end
      in_valid_i <= offering;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    out_word_t want;
    logic      rdy;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (verdict_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= ReportMaxC)
            $display("ERROR result %0d with nothing pending: ch=%0d smp=%h st=%0d sum=%h",
                     results_seen, out_data_o.out_channel, out_data_o.out_sample,
                     out_data_o.status, out_data_o.window_sum);
        end else begin
          want = verdict_q.pop_front();
          if (out_data_o.out_channel !== want.out_channel ||
              out_data_o.out_sample  !== want.out_sample  ||
              out_data_o.status      !== want.status      ||
              out_data_o.window_sum  !== want.window_sum) begin
            mismatch_cnt++;
            if (mismatch_cnt <= ReportMaxC) begin
              $display("ERROR result %0d: exp ch=%0d smp=%h st=%0d sum=%h",
                       results_seen, want.out_channel, want.out_sample, want.status,
                       want.window_sum);
              $display("  got ch=%0d smp=%h st=%0d sum=%h",
                       out_data_o.out_channel, out_data_o.out_sample,
                       out_data_o.status, out_data_o.window_sum);
            end
          end
        end
        rx_wait = $urandom_range(0, rx_max_stall);
        // one long hold so the block backs up and stalls its input
        if (results_seen == HoldAtC) rx_wait = HoldCyclesC;
      end
      if (rx_wait > 0) begin
        rx_wait--;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      out_ready_i <= rdy;
    end
  end

  initial begin : stimulus
    logic [CfgW-1:0] sig;
    for (int c = 0; c < ChanC; c++) begin
      wr_pos[c]   = 0;
      fill_cnt[c] = 0;
      for (int i = 0; i < HistC; i++) win_mem[c][i] = '0;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset threshold of 3 sigma; both deviations below sit exactly on it
    repeat (HistC) push_rate_word('1, '0);
    push_rate_word('1, '0);       // flat window at zero
    push_rate_word('1, RailC);    // one rail among zeros: equal, not flagged
    repeat (HistC) push_rate_word('0, RailC);
    push_rate_word('0, RailC);    // flat window, largest sum
    push_rate_word('0, '0);       // zero among rails: equal, not flagged
    wait_drained();

    for (int p = 0; p < PhasesC; p++) begin
      case (p)
        0:       sig = '0;
        1:       sig = '1;
        2:       sig = 8'd1;
        3:       sig = CfgW'($urandom_range(2, 254));
        default: sig = SigmaResetC;
      endcase
      tx_max_gap   = (p == 2) ? 0 : MaxGapC;
      rx_max_stall = (p == 2) ? 0 : MaxGapC;
      write_sigma(sig);
      push_random_words(RandWordsC);
      wait_drained();
    end
    repeat (TailCyclesC) @(posedge clk_i);

    mismatch_cnt += verdict_q.size();
    $display("Covered %0d sample words on %0d channels, thresholds incl. 0 and 255",
             words_taken, ChanC);
    $display("Verdicts seen: %0d collecting, %0d flat, %0d normal, %0d anomaly",
             status_seen[STAT_COLLECT], status_seen[STAT_FLAT],
             status_seen[STAT_NORMAL], status_seen[STAT_ANOMALY]);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

/* files.f */
hw/rtl/zrad_pkg.sv
hw/rtl/zscore_rate_anomaly_detector.sv
hw/rtl/zrad_checker.sv
test/zscore_rate_anomaly_detector_tb.sv
